@@ design/gba_pkg.sv @@
package gba_pkg;

  localparam int MaxWidth    = 4096;
  localparam int MaxBlock    = 64;
  localparam int HeightLimit = 4096;

  localparam int ChanW    = 8;
  localparam int GrayW    = 8;
  localparam int GraySumW = 24;
  localparam int PosW     = 12;
  localparam int OffW     = 6;
  localparam int BsW      = 7;
  localparam int DimW     = 13;
  localparam int RunSumW  = 14;
  localparam int ColSumW  = 20;
  localparam int DenW     = 13;
  localparam int AvgW     = 16;
  localparam int TileW    = 12;
  localparam int LineAddrW = $clog2(MaxWidth);
  localparam int CntW     = $clog2(AvgW + 1);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBlockSize   = 2'd2;

  localparam logic [DimW-1:0] WidthReset  = 13'd640;
  localparam logic [DimW-1:0] HeightReset = 13'd480;
  localparam logic [BsW-1:0]  BlockReset  = 7'd8;

  localparam logic [DimW-1:0] WidthLimit  = DimW'(MaxWidth);
  localparam logic [DimW-1:0] HeightMax   = DimW'(HeightLimit);
  localparam logic [BsW-1:0]  BlockLimit  = BsW'(MaxBlock);

  localparam logic [GraySumW-1:0] CoefRed   = 24'd19589;
  localparam logic [GraySumW-1:0] CoefGreen = 24'd38470;
  localparam logic [GraySumW-1:0] CoefBlue  = 24'd7471;
  localparam logic [GraySumW-1:0] GrayRound = 24'd32768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [ColSumW-1:0] num;
    logic [DenW-1:0]    den;
  } div_req_t;

endpackage

@@ design/gba_pix_if.sv @@
interface gba_pix_if;
  logic                       valid;
  logic                       ready;
  logic [gba_pkg::ChanW-1:0]  red;
  logic [gba_pkg::ChanW-1:0]  green;
  logic [gba_pkg::ChanW-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ design/gba_tile_if.sv @@
interface gba_tile_if;
  logic                       valid;
  logic                       ready;
  logic [gba_pkg::AvgW-1:0]   tile_average;
  logic [gba_pkg::TileW-1:0]  tile_column;
  logic [gba_pkg::TileW-1:0]  tile_row;
  logic                       final_tile;

  modport source (output valid, output tile_average, output tile_column,
                  output tile_row, output final_tile, input ready);
  modport sink   (input valid, input tile_average, input tile_column,
                  input tile_row, input final_tile, output ready);
endinterface

@@ design/grayscale_block_average_top.sv @@
// Channel | Direction | Transfer
// pix_i   | in        | one RGB pixel, raster order
// tile_o  | out       | one tile average with tile position and last-tile flag
// cfg     | in        | register write when cfg_we_i is high
//
// A pixel that does not finish a tile gets a line store read on acceptance and,
// in the next cycle, the read-modify-write of the column sum at a tile row's end.
// A tile-finishing pixel then waits for the bit-serial divider, and longer
// while the output register still holds an untaken result.
// Reset loads 640, 480 and 8 and clears the counters; the line store is not
// cleared, since every entry is written on a band's first row before use.
module grayscale_block_average_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gba_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gba_pkg::CfgDataW-1:0]  cfg_data_i,
  gba_pix_if.sink                       pix_i,
  gba_tile_if.source                    tile_o
);

  gba_pkg::state_e state_q, state_d;

  logic [gba_pkg::DimW-1:0]    w_q, h_q;
  logic [gba_pkg::BsW-1:0]     bs_q;
  logic [gba_pkg::DenW-1:0]    bs_sq_q;

  logic [gba_pkg::PosW-1:0]    px_q, py_q, tx_q, ty_q;
  logic [gba_pkg::OffW-1:0]    ox_q, oy_q;
  logic [gba_pkg::RunSumW-1:0] rrs_q;

  logic [gba_pkg::GrayW-1:0]   gray_q;
  logic                        act_q, first_x_q, end_x_q, first_y_q, end_y_q, final_q;
  logic [gba_pkg::TileW-1:0]   tcol_q, trow_q;
  logic [gba_pkg::ColSumW-1:0] rd_q;

  logic                        out_valid_q;
  logic [gba_pkg::AvgW-1:0]    avg_q;
  logic [gba_pkg::TileW-1:0]   out_col_q, out_row_q;
  logic                        out_fin_q;

  logic [gba_pkg::ColSumW-1:0] line_mem [gba_pkg::MaxWidth];

  logic                        pix_acc, cfg_hit, mem_we, div_start, out_load, out_free;
  logic [gba_pkg::GraySumW-1:0] gray_sum;
  logic [gba_pkg::DimW-1:0]    px_inc, py_inc;
  logic [gba_pkg::BsW-1:0]     ox_inc, oy_inc;
  logic [gba_pkg::PosW-1:0]    tsx, tsy;
  logic                        fits_x, fits_y, last_x, last_y;
  logic [gba_pkg::RunSumW-1:0] rrs_new;
  logic [gba_pkg::ColSumW-1:0] col;
  logic [gba_pkg::DimW-1:0]    dim_clamp;
  logic [gba_pkg::BsW-1:0]     bs_clamp;
  gba_pkg::div_req_t           div_req;
  logic                        div_busy;
  logic [gba_pkg::AvgW-1:0]    div_quot;

  assign pix_i.ready = (state_q == gba_pkg::ST_IDLE);
  assign pix_acc     = pix_i.valid && pix_i.ready;
  assign out_free    = !out_valid_q || tile_o.ready;

  assign gray_sum = gba_pkg::CoefRed   * gba_pkg::GraySumW'(pix_i.red)
                  + gba_pkg::CoefGreen * gba_pkg::GraySumW'(pix_i.green)
                  + gba_pkg::CoefBlue  * gba_pkg::GraySumW'(pix_i.blue)
                  + gba_pkg::GrayRound;

  assign px_inc = {1'b0, px_q} + 1'b1;
  assign py_inc = {1'b0, py_q} + 1'b1;
  assign ox_inc = {1'b0, ox_q} + 1'b1;
  assign oy_inc = {1'b0, oy_q} + 1'b1;
  assign tsx    = px_q - gba_pkg::PosW'(ox_q);
  assign tsy    = py_q - gba_pkg::PosW'(oy_q);
  assign fits_x = (14'(tsx) + 14'(bs_q)) <= 14'(w_q);
  assign fits_y = (14'(tsy) + 14'(bs_q)) <= 14'(h_q);
  assign last_x = (14'(tsx) + {6'd0, bs_q, 1'b0}) > 14'(w_q);
  assign last_y = (14'(tsy) + {6'd0, bs_q, 1'b0}) > 14'(h_q);

  assign rrs_new = first_x_q ? gba_pkg::RunSumW'(gray_q) : rrs_q + gba_pkg::RunSumW'(gray_q);
  assign col     = first_y_q ? gba_pkg::ColSumW'(rrs_new) : rd_q + gba_pkg::ColSumW'(rrs_new);

  assign dim_clamp = (cfg_data_i == '0) ? gba_pkg::DimW'(1) :
                     (cfg_data_i > gba_pkg::WidthLimit) ? gba_pkg::WidthLimit : cfg_data_i;
  assign bs_clamp  = (cfg_data_i[gba_pkg::BsW-1:0] == '0) ? gba_pkg::BsW'(1) :
                     (cfg_data_i[gba_pkg::BsW-1:0] > gba_pkg::BlockLimit) ?
                     gba_pkg::BlockLimit : cfg_data_i[gba_pkg::BsW-1:0];
  assign cfg_hit   = cfg_we_i && (cfg_index_i == gba_pkg::RegImageWidth ||
                                  cfg_index_i == gba_pkg::RegImageHeight ||
                                  cfg_index_i == gba_pkg::RegBlockSize);

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      gba_pkg::ST_IDLE: begin
        if (pix_acc) begin
          state_d = gba_pkg::ST_UPDATE;
        end
      end
      gba_pkg::ST_UPDATE: begin
        mem_we = act_q && end_x_q;
        if (act_q && end_x_q && end_y_q) begin
          div_start = 1'b1;
          state_d   = gba_pkg::ST_DIV;
        end else begin
          state_d = gba_pkg::ST_IDLE;
        end
      end
      gba_pkg::ST_DIV: begin
        if (!div_busy && out_free) begin
          out_load = 1'b1;
          state_d  = gba_pkg::ST_IDLE;
        end
      end
      default: state_d = gba_pkg::ST_IDLE;
    endcase
  end

  assign div_req.num = col;
  assign div_req.den = bs_sq_q;

  gba_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gba_pkg::ST_IDLE;
      w_q         <= gba_pkg::WidthReset;
      h_q         <= gba_pkg::HeightReset;
      bs_q        <= gba_pkg::BlockReset;
      bs_sq_q     <= gba_pkg::DenW'(64);
      px_q        <= '0;
      py_q        <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      tx_q        <= '0;
      ty_q        <= '0;
      rrs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bs_sq_q <= gba_pkg::DenW'(bs_q) * gba_pkg::DenW'(bs_q);
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          gba_pkg::RegImageWidth:  w_q  <= dim_clamp;
          gba_pkg::RegImageHeight: h_q  <= (dim_clamp > gba_pkg::HeightMax) ?
                                           gba_pkg::HeightMax : dim_clamp;
          gba_pkg::RegBlockSize:   bs_q <= bs_clamp;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        px_q  <= '0;
        py_q  <= '0;
        ox_q  <= '0;
        oy_q  <= '0;
        tx_q  <= '0;
        ty_q  <= '0;
        rrs_q <= '0;
      end else if (pix_acc) begin
        if (px_inc >= w_q) begin
          px_q <= '0;
          ox_q <= '0;
          tx_q <= '0;
          if (py_inc >= h_q) begin
            py_q <= '0;
            oy_q <= '0;
            ty_q <= '0;
          end else begin
            py_q <= py_inc[gba_pkg::PosW-1:0];
            if (oy_inc >= bs_q) begin
              oy_q <= '0;
              ty_q <= ty_q + 1'b1;
            end else begin
              oy_q <= oy_inc[gba_pkg::OffW-1:0];
            end
          end
        end else begin
          px_q <= px_inc[gba_pkg::PosW-1:0];
          if (ox_inc >= bs_q) begin
            ox_q <= '0;
            tx_q <= tx_q + 1'b1;
          end else begin
            ox_q <= ox_inc[gba_pkg::OffW-1:0];
          end
        end
      end else if (state_q == gba_pkg::ST_UPDATE && act_q) begin
        rrs_q <= rrs_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (tile_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      gray_q    <= gray_sum[gba_pkg::GraySumW-1:16];
      act_q     <= fits_x && fits_y;
      first_x_q <= (ox_q == '0);
      end_x_q   <= (ox_inc == bs_q);
      first_y_q <= (oy_q == '0);
      end_y_q   <= (oy_inc == bs_q);
      final_q   <= last_x && last_y;
      tcol_q    <= tx_q;
      trow_q    <= ty_q;
    end
    if (out_load) begin
      avg_q     <= div_quot;
      out_col_q <= tcol_q;
      out_row_q <= trow_q;
      out_fin_q <= final_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[tcol_q[gba_pkg::LineAddrW-1:0]] <= col;
    end
    if (pix_acc) begin
      rd_q <= line_mem[tx_q[gba_pkg::LineAddrW-1:0]];
    end
  end

  assign tile_o.valid        = out_valid_q;
  assign tile_o.tile_average = avg_q;
  assign tile_o.tile_column  = out_col_q;
  assign tile_o.tile_row     = out_row_q;
  assign tile_o.final_tile   = out_fin_q;

endmodule

@@ design/gba_div.sv @@
module gba_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  gba_pkg::div_req_t         req_i,
  output logic                      busy_o,
  output logic [gba_pkg::AvgW-1:0]  quot_o
);

  logic [gba_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [gba_pkg::TileW-1:0]    rem_q, rem_d;
  logic [gba_pkg::DenW-1:0]     den_q, den_d;
  logic [gba_pkg::AvgW-1:0]     bits_q, bits_d;
  logic [gba_pkg::AvgW-1:0]     quot_q, quot_d;
  logic [gba_pkg::DenW-1:0]     trial;
  logic [gba_pkg::DenW-1:0]     diff;
  logic                         take;

  // The numerator is the column sum shifted left by eight; its top twelve
  // bits are already below the divisor, so sixteen steps give the quotient.
  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    bits_d = bits_q;
    quot_d = quot_q;
    trial  = {rem_q, bits_q[gba_pkg::AvgW-1]};
    take   = (trial >= den_q);
    diff   = trial - den_q;
    if (start_i) begin
      cnt_d  = gba_pkg::CntW'(gba_pkg::AvgW);
      rem_d  = req_i.num[gba_pkg::ColSumW-1:8];
      den_d  = req_i.den;
      bits_d = {req_i.num[7:0], 8'd0};
      quot_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      rem_d  = take ? diff[gba_pkg::TileW-1:0] : trial[gba_pkg::TileW-1:0];
      bits_d = {bits_q[gba_pkg::AvgW-2:0], 1'b0};
      quot_d = {quot_q[gba_pkg::AvgW-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    bits_q <= bits_d;
    quot_q <= quot_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;

endmodule
